>>> sv/ret_pkg.sv
// ============================================================================
// ret_pkg : shared types and constants for the repeat event throttle
// Table geometry, transaction payloads, status codes and table port bundles.
// ============================================================================
package ret_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int KEY_BITS      = 32;   // compared key bits, at most TIME_W
    localparam int TIME_W        = 32;
    localparam int CNT_W         = 16;
    localparam int CFG_W         = 16;
    localparam int CFG_IDX_W     = 8;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int USED_W        = $clog2(TABLE_ENTRIES + 1);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_BURST    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_SUPPRESS = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_REPRINT  = CFG_IDX_W'(3);

    localparam logic [CFG_W-1:0] WINDOW_RST   = CFG_W'(60);
    localparam logic [CFG_W-1:0] BURST_RST    = CFG_W'(60);
    localparam logic [CFG_W-1:0] SUPPRESS_RST = CFG_W'(3600);
    localparam logic [CFG_W-1:0] REPRINT_RST  = CFG_W'(3600);

    // status codes
    localparam logic [1:0] ST_NEW   = 2'd0;
    localparam logic [1:0] ST_KNOWN = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [31:0] event_key;
        logic [31:0] now_seconds;
    } t_in_item;

    typedef struct packed {
        logic       report;
        logic [1:0] status;
    } t_out_item;

    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic [TIME_W-1:0]   window_start;
        logic [CNT_W-1:0]    window_count;
        logic [TIME_W-1:0]   suppress_end;
        logic [TIME_W-1:0]   last_report;
    } t_entry;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
    } t_tbl_req;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } t_alu_op;

endpackage

>>> sv/ret_alu.sv
// ============================================================================
// ret_alu : shared add/subtract unit
// One 32-bit adder for key match, time differences, threshold compares, sums.
// ============================================================================
module ret_alu
    import ret_pkg::*;
(
    input  t_alu_op           i_op,
    input  logic [TIME_W-1:0] i_a,
    input  logic [TIME_W-1:0] i_b,
    output logic [TIME_W:0]   o_res,   // msb: carry on add, borrow on subtract
    output logic              o_zero
);

    always_comb begin
        if (i_op == ALU_SUB) begin
            o_res = {1'b0, i_a} - {1'b0, i_b};
        end else begin
            o_res = {1'b0, i_a} + {1'b0, i_b};
        end
    end

    assign o_zero = (o_res[TIME_W-1:0] == '0);

endmodule

>>> sv/ret_table.sv
// ============================================================================
// ret_table : tracked key table
// One write port and one read port with registered read data.
// ============================================================================
module ret_table
    import ret_pkg::*;
(
    input  logic     i_clk,
    input  t_tbl_req i_req,
    input  t_entry   i_wr_data,
    output t_entry   o_rd_data
);

    t_entry mem [TABLE_ENTRIES];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            mem[i_req.wr_addr] <= i_wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> sv/repeat_event_throttle.sv
// ============================================================================
// repeat_event_throttle : repeat event rate limiter
// Decides per event whether to report it, tracking up to TABLE_ENTRIES keys.
// ============================================================================
// Usage
//   Input channel (i_in_valid / o_in_stall / i_in_data): one transaction is an
//   event key plus the current time in seconds. Time must not go backwards.
//   Output channel (o_out_valid / i_out_stall / o_out_data): one transaction
//   per event, carrying report (1 = print) and status (new/known/full).
//   Config channel (i_cfg_valid / o_cfg_ready, always ready): writes window,
//   burst limit, suppress and reprint lengths; write only while idle.
// Timing
//   The table is scanned one entry per cycle through a registered-read
//   memory; the read of one entry goes out while the previous one is
//   compared. A known key then takes up to five steps through the one
//   shared adder (suppress check, reprint gap, window gap, burst compare,
//   saturating suppress end), then a table write. One event is in flight
//   at once; the next one can be accepted in the cycle after the result
//   is loaded into the output register.
//   o_in_stall is high from accept until the result is in the output reg.
// Reset
//   Synchronous, active low: table empties (fill count zero), registers
//   return to 60 / 60 / 3600 / 3600, output goes invalid. No clearing pass.
// Backpressure
//   A finished result waits in the output register while i_out_stall is
//   high; the next event may be accepted and worked on meanwhile, and it
//   only waits at the end if the register is still occupied.
// ============================================================================
module repeat_event_throttle
    import ret_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // event input
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_data,
    // result output
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_data,
    // configuration writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_SCAN  = 11'b000_0000_0010,
        S_SUP   = 11'b000_0000_0100,
        S_RPR   = 11'b000_0000_1000,
        S_RPR2  = 11'b000_0001_0000,
        S_WIN   = 11'b000_0010_0000,
        S_WIN2  = 11'b000_0100_0000,
        S_BURST = 11'b000_1000_0000,
        S_SEND  = 11'b001_0000_0000,
        S_WRITE = 11'b010_0000_0000,
        S_DONE  = 11'b100_0000_0000
    } t_state;

    // config registers
    logic [CFG_W-1:0] r_window, r_burst, r_suppress, r_reprint;

    // sequencer state
    t_state            r_state, n_state;
    logic [USED_W-1:0] r_used, n_used;
    logic [USED_W-1:0] r_idx, n_idx;
    logic              r_pend, n_pend;
    logic [IDX_W-1:0]  r_pend_idx, n_pend_idx;
    logic [IDX_W-1:0]  r_hit_idx, n_hit_idx;
    logic [KEY_BITS-1:0] r_key, n_key;
    logic [TIME_W-1:0] r_now, n_now;
    logic [TIME_W-1:0] r_tmp, n_tmp;
    t_entry            r_ent, n_ent;
    logic              r_report, n_report;
    logic [1:0]        r_status, n_status;

    // output register
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out, n_out;

    // shared unit and table
    t_alu_op           alu_op;
    logic [TIME_W-1:0] alu_a, alu_b;
    logic [TIME_W:0]   alu_res;
    logic              alu_zero;
    t_tbl_req          tbl_req;
    t_entry            tbl_rd;

    logic in_acc;
    logic out_free;
    logic hit;

    ret_alu u_alu (
        .i_op   (alu_op),
        .i_a    (alu_a),
        .i_b    (alu_b),
        .o_res  (alu_res),
        .o_zero (alu_zero)
    );

    ret_table u_table (
        .i_clk     (i_clk),
        .i_req     (tbl_req),
        .i_wr_data (r_ent),
        .o_rd_data (tbl_rd)
    );

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // config writes; out of range indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window   <= WINDOW_RST;
            r_burst    <= BURST_RST;
            r_suppress <= SUPPRESS_RST;
            r_reprint  <= REPRINT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_WINDOW:   r_window   <= i_cfg_data;
                CFG_BURST:    r_burst    <= i_cfg_data;
                CFG_SUPPRESS: r_suppress <= i_cfg_data;
                CFG_REPRINT:  r_reprint  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // shared adder operand selection
    always_comb begin
        alu_op = ALU_SUB;
        alu_a  = '0;
        alu_b  = '0;
        unique case (r_state)
            S_SCAN: begin
                alu_a = TIME_W'(tbl_rd.key);
                alu_b = TIME_W'(r_key);
            end
            S_SUP: begin   // now <= suppress_end when no borrow
                alu_a = r_ent.suppress_end;
                alu_b = r_now;
            end
            S_RPR: begin
                alu_a = r_now;
                alu_b = r_ent.last_report;
            end
            S_RPR2: begin  // gap >= reprint when no borrow
                alu_a = r_tmp;
                alu_b = TIME_W'(r_reprint);
            end
            S_WIN: begin
                alu_a = r_now;
                alu_b = r_ent.window_start;
            end
            S_WIN2: begin  // gap <= window when no borrow
                alu_a = TIME_W'(r_window);
                alu_b = r_tmp;
            end
            S_BURST: begin // count >= burst when no borrow
                alu_a = TIME_W'(r_ent.window_count);
                alu_b = TIME_W'(r_burst);
            end
            S_SEND: begin
                alu_op = ALU_ADD;
                alu_a  = r_now;
                alu_b  = TIME_W'(r_suppress);
            end
            S_IDLE, S_WRITE, S_DONE: ;
            default: ;
        endcase
    end

    assign hit = r_pend && alu_zero;

    always_comb begin
        n_state     = r_state;
        n_used      = r_used;
        n_idx       = r_idx;
        n_pend      = r_pend;
        n_pend_idx  = r_pend_idx;
        n_hit_idx   = r_hit_idx;
        n_key       = r_key;
        n_now       = r_now;
        n_tmp       = r_tmp;
        n_ent       = r_ent;
        n_report    = r_report;
        n_status    = r_status;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        tbl_req     = '0;
        tbl_req.wr_addr = r_hit_idx;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_key   = i_in_data.event_key[KEY_BITS-1:0];
                    n_now   = i_in_data.now_seconds;
                    n_idx   = '0;
                    n_pend  = 1'b0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                // read of entry idx goes out while entry idx-1 is compared
                if (hit) begin
                    n_ent     = tbl_rd;
                    n_hit_idx = r_pend_idx;
                    n_status  = ST_KNOWN;
                    n_report  = 1'b1;
                    n_state   = S_SUP;
                end else if (r_idx >= r_used) begin
                    n_report = 1'b1;
                    if (r_used < USED_W'(TABLE_ENTRIES)) begin
                        n_ent.key          = r_key;
                        n_ent.window_start = r_now;
                        n_ent.window_count = CNT_W'(1);
                        n_ent.suppress_end = '0;
                        n_ent.last_report  = r_now;
                        n_hit_idx = r_used[IDX_W-1:0];
                        n_used    = r_used + USED_W'(1);
                        n_status  = ST_NEW;
                        n_state   = S_WRITE;
                    end else begin
                        n_status = ST_FULL;
                        n_state  = S_DONE;
                    end
                end else begin
                    tbl_req.rd_en   = 1'b1;
                    tbl_req.rd_addr = r_idx[IDX_W-1:0];
                    n_pend_idx      = r_idx[IDX_W-1:0];
                    n_pend          = 1'b1;
                    n_idx           = r_idx + USED_W'(1);
                end
            end
            S_SUP: begin
                n_state = alu_res[TIME_W] ? S_WIN : S_RPR;
            end
            S_RPR: begin
                n_tmp   = alu_res[TIME_W-1:0];
                n_state = S_RPR2;
            end
            S_RPR2: begin
                if (!alu_res[TIME_W]) begin
                    n_ent.last_report = r_now;
                    n_report = 1'b1;
                end else begin
                    n_report = 1'b0;
                end
                n_state = S_WRITE;
            end
            S_WIN: begin
                n_tmp   = alu_res[TIME_W-1:0];
                n_state = S_WIN2;
            end
            S_WIN2: begin
                if (!alu_res[TIME_W]) begin
                    if (r_ent.window_count != '1) begin
                        n_ent.window_count = r_ent.window_count + CNT_W'(1);
                    end
                    n_state = S_BURST;
                end else begin
                    n_ent.window_start = r_now;
                    n_ent.window_count = CNT_W'(1);
                    n_state = S_WRITE;
                end
            end
            S_BURST: begin
                n_state = alu_res[TIME_W] ? S_WRITE : S_SEND;
            end
            S_SEND: begin
                // saturate on carry out
                n_ent.suppress_end = alu_res[TIME_W] ? '1 : alu_res[TIME_W-1:0];
                n_ent.last_report  = r_now;
                n_state = S_WRITE;
            end
            S_WRITE: begin
                tbl_req.wr_en = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid   = 1'b1;
                    n_out.report  = r_report;
                    n_out.status  = r_status;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_idx       <= n_idx;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        r_pend_idx <= n_pend_idx;
        r_hit_idx  <= n_hit_idx;
        r_key      <= n_key;
        r_now      <= n_now;
        r_tmp      <= n_tmp;
        r_ent      <= n_ent;
        r_report   <= n_report;
        r_status   <= n_status;
        r_out      <= n_out;
    end

endmodule

>>> sv/ret_checker.sv
// ============================================================================
// ret_checker : port level checks for the repeat event throttle
// Watches the event and result channels of the top level; attached by bind.
// ============================================================================
module ret_checker
    import ret_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_data
);

    logic in_acc;
    assign in_acc = i_in_valid && !o_in_stall;

    // stalled result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("output transaction dropped or changed under stall");

    // one event in flight: stall right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("second transaction accepted while busy");

    // result needs at least a scan step
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !$rose(o_out_valid))
        else $error("result appeared one cycle after accept");

    // new and untracked keys are always reported
    a_new_full_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status == ST_NEW || o_out_data.status == ST_FULL))
            |-> o_out_data.report)
        else $error("new or untracked event suppressed");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.status != 2'd3))
        else $error("undefined status code");

endmodule

bind repeat_event_throttle ret_checker u_ret_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
